[rtl/elg_pkg.sv]
`timescale 1ns / 1ps
package elg_pkg;
	localparam int DEF_WIDTH = 32;

	localparam logic [1:0] REG_MODULUS   = 2'd0;
	localparam logic [1:0] REG_GENERATOR = 2'd1;
	localparam logic [1:0] REG_PRIVKEY   = 2'd2;

	localparam logic FUNC_SIGN   = 1'b0;
	localparam logic FUNC_VERIFY = 1'b1;

	localparam logic ERR_NONE     = 1'b0;
	localparam logic ERR_NO_INV   = 1'b1;

	localparam int RST_MODULUS   = 5;
	localparam int RST_GENERATOR = 2;
	localparam int RST_PRIVKEY   = 2;
endpackage

[rtl/elg_cell.sv]
`timescale 1ns / 1ps
module elg_cell import elg_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             v_in,
	input  logic [WIDTH-1:0] acc_in,
	input  logic [WIDTH-1:0] a_in,
	input  logic [WIDTH-1:0] b_in,
	input  logic [WIDTH-1:0] m_in,
	output logic             v_out,
	output logic [WIDTH-1:0] acc_out,
	output logic [WIDTH-1:0] a_out,
	output logic [WIDTH-1:0] b_out,
	output logic [WIDTH-1:0] m_out
);
	logic             v_q;
	logic [WIDTH-1:0] acc_q, a_q, b_q, m_q;
	logic [WIDTH-1:0] room_acc, room_dbl, sum_acc, sum_dbl;

	// Operands are below m, so (x + y) mod m needs one compare and one subtract.
	always_comb begin
		room_acc = m_in - a_in;
		sum_acc  = (acc_in >= room_acc) ? acc_in - room_acc : acc_in + a_in;
		room_dbl = m_in - a_in;
		sum_dbl  = (a_in >= room_dbl) ? a_in - room_dbl : a_in + a_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		acc_q <= b_in[0] ? sum_acc : acc_in;
		a_q   <= sum_dbl;
		b_q   <= b_in >> 1;
		m_q   <= m_in;
	end

	assign v_out   = v_q;
	assign acc_out = acc_q;
	assign a_out   = a_q;
	assign b_out   = b_q;
	assign m_out   = m_q;
endmodule

[rtl/elg_mulchain.sv]
`timescale 1ns / 1ps
module elg_mulchain import elg_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	input  logic [WIDTH-1:0] m,
	output logic             done,
	output logic [WIDTH-1:0] res
);
	logic             v   [WIDTH+1];
	logic [WIDTH-1:0] acc [WIDTH+1];
	logic [WIDTH-1:0] aa  [WIDTH+1];
	logic [WIDTH-1:0] bb  [WIDTH+1];
	logic [WIDTH-1:0] mm  [WIDTH+1];
	logic             done_q;
	logic [WIDTH-1:0] res_q;

	assign v[0]   = go;
	assign acc[0] = '0;
	assign aa[0]  = a;
	assign bb[0]  = b;
	assign mm[0]  = m;

	// Each cell consumes one multiplier bit and passes its partial product on.
	for (genvar i = 0; i < WIDTH; i++) begin : g_cell
		elg_cell #(.WIDTH(WIDTH)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.v_in   (v[i]),
			.acc_in (acc[i]),
			.a_in   (aa[i]),
			.b_in   (bb[i]),
			.m_in   (mm[i]),
			.v_out  (v[i+1]),
			.acc_out(acc[i+1]),
			.a_out  (aa[i+1]),
			.b_out  (bb[i+1]),
			.m_out  (mm[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v[WIDTH];
		end
	end

	always_ff @(posedge clk) begin
		if (v[WIDTH]) begin
			res_q <= acc[WIDTH];
		end
	end

	assign done = done_q;
	assign res  = res_q;
endmodule

[rtl/elg_div.sv]
`timescale 1ns / 1ps
module elg_div import elg_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [WIDTH-1:0] num,
	input  logic [WIDTH-1:0] den,
	output logic             done,
	output logic [WIDTH-1:0] quo,
	output logic [WIDTH-1:0] rem
);
	localparam int CW = $clog2(WIDTH);

	logic          busy_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [WIDTH-1:0] quo_q, rem_q, den_q;
	logic [WIDTH:0]   trial;
	logic             fits;

	always_comb begin
		trial = {rem_q, quo_q[WIDTH-1]};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring division, one quotient bit per cycle; the dividend shifts out
	// of the top of quo_q as the quotient shifts in at the bottom.
	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[WIDTH-2:0], fits};
			rem_q <= fits ? WIDTH'(trial - {1'b0, den_q}) : trial[WIDTH-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule

[rtl/elgamal_sign_verify.sv]
`timescale 1ns / 1ps
// ElGamal signature engine. Write modulus p, generator g and private key x
// through the configuration port while the engine is idle. Each transfer on
// the input side either signs (func 0) a hash with a nonce or verifies (func 1)
// a pair r, s, and yields one result carrying the public key g^x mod p, or
// zero when p is below 2. One item is worked at a time. Every modular
// product runs through a chain of WIDTH cells, one multiplier bit per cell,
// and every reduction runs through the bit-serial divider. A verify takes
// four exponentiations, and a sign two plus the extended Euclid loop that
// inverts the nonce. A finished result waits in the output register while
// the next item is accepted.
module elgamal_sign_verify import elg_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             func,
	input  logic [WIDTH-1:0] message_hash,
	input  logic [WIDTH-1:0] nonce,
	input  logic [WIDTH-1:0] check_r,
	input  logic [WIDTH-1:0] check_s,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [WIDTH-1:0] public_key,
	output logic [WIDTH-1:0] sig_r,
	output logic [WIDTH-1:0] sig_s,
	output logic             valid_res,
	output logic             error_code,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [WIDTH-1:0] cfg_data
);
	localparam int IW = $clog2(WIDTH);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_WAIT = 5'd1;
	localparam logic [4:0] S_Y1   = 5'd2;
	localparam logic [4:0] S_P0   = 5'd3;
	localparam logic [4:0] S_P1   = 5'd4;
	localparam logic [4:0] S_P2   = 5'd5;
	localparam logic [4:0] S_P3   = 5'd6;
	localparam logic [4:0] S_P4   = 5'd7;
	localparam logic [4:0] S_P5   = 5'd8;
	localparam logic [4:0] S_K0   = 5'd9;
	localparam logic [4:0] S_K1   = 5'd10;
	localparam logic [4:0] S_K2   = 5'd11;
	localparam logic [4:0] S_K3   = 5'd12;
	localparam logic [4:0] S_K4   = 5'd13;
	localparam logic [4:0] S_K5   = 5'd14;
	localparam logic [4:0] S_K6   = 5'd15;
	localparam logic [4:0] S_K7   = 5'd16;
	localparam logic [4:0] S_K8   = 5'd17;
	localparam logic [4:0] S_K9   = 5'd18;
	localparam logic [4:0] S_K10  = 5'd19;
	localparam logic [4:0] S_K11  = 5'd20;
	localparam logic [4:0] S_V1   = 5'd21;
	localparam logic [4:0] S_V2   = 5'd22;
	localparam logic [4:0] S_V3   = 5'd23;
	localparam logic [4:0] S_V4   = 5'd24;
	localparam logic [4:0] S_OUT  = 5'd25;

	logic [4:0] state_q, nxt_q, ret_q;

	logic [WIDTH-1:0] p_q, g_q, x_q;
	logic             func_q;
	logic [WIDTH-1:0] m_q, k_q, cr_q, cs_q;
	logic [WIDTH-1:0] y_q, r_q, s_q, lhs_q, tmp_q;
	logic             vres_q, err_q;
	logic [WIDTH-1:0] r0_q, r1_q, t0_q, t1_q;
	logic [WIDTH-1:0] pb_q, pe_q, pm_q, pacc_q;
	logic [IW-1:0]    pi_q;

	logic             mul_go_q, div_go_q;
	logic [WIDTH-1:0] mul_a_q, mul_b_q, mul_m_q, div_n_q, div_d_q;
	logic             mul_done, div_done;
	logic [WIDTH-1:0] mul_res, div_quo, div_rem;

	logic             out_valid_q, error_code_q, valid_res_q;
	logic [WIDTH-1:0] public_key_q, sig_r_q, sig_s_q;

	logic [WIDTH-1:0] n_w, qm_w, nt_w, d_w;
	logic             accept, load_out;

	elg_mulchain #(.WIDTH(WIDTH)) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (mul_go_q),
		.a     (mul_a_q),
		.b     (mul_b_q),
		.m     (mul_m_q),
		.done  (mul_done),
		.res   (mul_res)
	);

	elg_div #(.WIDTH(WIDTH)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (div_go_q),
		.num   (div_n_q),
		.den   (div_d_q),
		.done  (div_done),
		.quo   (div_quo),
		.rem   (div_rem)
	);

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign load_out  = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		n_w  = p_q - 1'b1;
		// The quotient never exceeds n; it equals n only when reduced to zero.
		qm_w = (div_quo == n_w) ? '0 : div_quo;
		nt_w = (t0_q >= mul_res) ? t0_q - mul_res : t0_q + (n_w - mul_res);
		d_w  = (div_rem >= tmp_q) ? div_rem - tmp_q : div_rem + (n_w - tmp_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= WIDTH'(RST_MODULUS);
			g_q <= WIDTH'(RST_GENERATOR);
			x_q <= WIDTH'(RST_PRIVKEY);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODULUS:   p_q <= cfg_data;
				REG_GENERATOR: g_q <= cfg_data;
				REG_PRIVKEY:   x_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			nxt_q    <= S_IDLE;
			ret_q    <= S_IDLE;
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
		end else begin
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q <= func;
						m_q    <= message_hash;
						k_q    <= nonce;
						cr_q   <= check_r;
						cs_q   <= check_s;
						y_q    <= '0;
						r_q    <= '0;
						s_q    <= '0;
						vres_q <= 1'b0;
						err_q  <= ERR_NONE;
						if (p_q < WIDTH'(2)) begin
							err_q   <= (func == FUNC_SIGN) ? ERR_NO_INV : ERR_NONE;
							state_q <= S_OUT;
						end else begin
							pb_q    <= g_q;
							pe_q    <= x_q;
							pm_q    <= p_q;
							ret_q   <= S_Y1;
							state_q <= S_P0;
						end
					end
				end
				S_WAIT: begin
					if (mul_done || div_done) begin
						state_q <= nxt_q;
					end
				end
				// Square-and-multiply over every exponent bit, low bit first.
				S_P0: begin
					div_go_q <= 1'b1;
					div_n_q  <= pb_q;
					div_d_q  <= pm_q;
					nxt_q    <= S_P1;
					state_q  <= S_WAIT;
				end
				S_P1: begin
					pb_q    <= div_rem;
					pacc_q  <= WIDTH'(1);
					pi_q    <= '0;
					state_q <= S_P2;
				end
				S_P2: begin
					if (pe_q[pi_q]) begin
						mul_go_q <= 1'b1;
						mul_a_q  <= pacc_q;
						mul_b_q  <= pb_q;
						mul_m_q  <= pm_q;
						nxt_q    <= S_P3;
						state_q  <= S_WAIT;
					end else begin
						state_q <= S_P4;
					end
				end
				S_P3: begin
					pacc_q  <= mul_res;
					state_q <= S_P4;
				end
				S_P4: begin
					mul_go_q <= 1'b1;
					mul_a_q  <= pb_q;
					mul_b_q  <= pb_q;
					mul_m_q  <= pm_q;
					nxt_q    <= S_P5;
					state_q  <= S_WAIT;
				end
				S_P5: begin
					pb_q <= mul_res;
					if (pi_q == IW'(WIDTH - 1)) begin
						state_q <= ret_q;
					end else begin
						pi_q    <= pi_q + 1'b1;
						state_q <= S_P2;
					end
				end
				S_Y1: begin
					y_q <= pacc_q;
					if (func_q == FUNC_SIGN) begin
						state_q <= S_K0;
					end else if (cr_q != '0 && cr_q < p_q && cs_q < n_w) begin
						pb_q    <= g_q;
						pe_q    <= m_q;
						pm_q    <= p_q;
						ret_q   <= S_V1;
						state_q <= S_P0;
					end else begin
						state_q <= S_OUT;
					end
				end
				// Extended Euclid on (p-1, k) for the nonce inverse.
				S_K0: begin
					div_go_q <= 1'b1;
					div_n_q  <= k_q;
					div_d_q  <= n_w;
					nxt_q    <= S_K1;
					state_q  <= S_WAIT;
				end
				S_K1: begin
					r0_q    <= n_w;
					r1_q    <= div_rem;
					t0_q    <= '0;
					t1_q    <= (n_w == WIDTH'(1)) ? '0 : WIDTH'(1);
					state_q <= S_K2;
				end
				S_K2: begin
					if (r1_q == '0) begin
						state_q <= S_K5;
					end else begin
						div_go_q <= 1'b1;
						div_n_q  <= r0_q;
						div_d_q  <= r1_q;
						nxt_q    <= S_K3;
						state_q  <= S_WAIT;
					end
				end
				S_K3: begin
					tmp_q    <= div_rem;
					mul_go_q <= 1'b1;
					mul_a_q  <= qm_w;
					mul_b_q  <= t1_q;
					mul_m_q  <= n_w;
					nxt_q    <= S_K4;
					state_q  <= S_WAIT;
				end
				S_K4: begin
					r0_q    <= r1_q;
					r1_q    <= tmp_q;
					t0_q    <= t1_q;
					t1_q    <= nt_w;
					state_q <= S_K2;
				end
				S_K5: begin
					if (r0_q != WIDTH'(1)) begin
						err_q   <= ERR_NO_INV;
						state_q <= S_OUT;
					end else begin
						pb_q    <= g_q;
						pe_q    <= k_q;
						pm_q    <= p_q;
						ret_q   <= S_K6;
						state_q <= S_P0;
					end
				end
				S_K6: begin
					r_q      <= pacc_q;
					div_go_q <= 1'b1;
					div_n_q  <= x_q;
					div_d_q  <= n_w;
					nxt_q    <= S_K7;
					state_q  <= S_WAIT;
				end
				S_K7: begin
					tmp_q    <= div_rem;
					div_go_q <= 1'b1;
					div_n_q  <= r_q;
					div_d_q  <= n_w;
					nxt_q    <= S_K8;
					state_q  <= S_WAIT;
				end
				S_K8: begin
					mul_go_q <= 1'b1;
					mul_a_q  <= tmp_q;
					mul_b_q  <= div_rem;
					mul_m_q  <= n_w;
					nxt_q    <= S_K9;
					state_q  <= S_WAIT;
				end
				S_K9: begin
					tmp_q    <= mul_res;
					div_go_q <= 1'b1;
					div_n_q  <= m_q;
					div_d_q  <= n_w;
					nxt_q    <= S_K10;
					state_q  <= S_WAIT;
				end
				S_K10: begin
					mul_go_q <= 1'b1;
					mul_a_q  <= t0_q;
					mul_b_q  <= d_w;
					mul_m_q  <= n_w;
					nxt_q    <= S_K11;
					state_q  <= S_WAIT;
				end
				S_K11: begin
					s_q     <= mul_res;
					state_q <= S_OUT;
				end
				S_V1: begin
					lhs_q   <= pacc_q;
					pb_q    <= y_q;
					pe_q    <= cr_q;
					pm_q    <= p_q;
					ret_q   <= S_V2;
					state_q <= S_P0;
				end
				S_V2: begin
					tmp_q   <= pacc_q;
					pb_q    <= cr_q;
					pe_q    <= cs_q;
					pm_q    <= p_q;
					ret_q   <= S_V3;
					state_q <= S_P0;
				end
				S_V3: begin
					mul_go_q <= 1'b1;
					mul_a_q  <= tmp_q;
					mul_b_q  <= pacc_q;
					mul_m_q  <= p_q;
					nxt_q    <= S_V4;
					state_q  <= S_WAIT;
				end
				S_V4: begin
					vres_q  <= (mul_res == lhs_q);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			public_key_q <= y_q;
			sig_r_q      <= r_q;
			sig_s_q      <= s_q;
			valid_res_q  <= vres_q;
			error_code_q <= err_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign public_key = public_key_q;
	assign sig_r      = sig_r_q;
	assign sig_s      = sig_s_q;
	assign valid_res  = valid_res_q;
	assign error_code = error_code_q;
endmodule

[rtl/elg_chk.sv]
`timescale 1ns / 1ps
module elg_chk import elg_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [WIDTH-1:0] sig_r,
	input logic [WIDTH-1:0] sig_s,
	input logic             valid_res,
	input logic             error_code
);
	// The engine works one item at a time, so a transfer in makes it busy.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a transfer");

	a_err_no_sig: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code == ERR_NO_INV |-> sig_r == '0 && sig_s == '0)
		else $error("signature reported with a nonce error");

	a_verify_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> error_code == ERR_NONE && sig_r == '0 && sig_s == '0)
		else $error("successful verify carries signature or error");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");
endmodule

bind elgamal_sign_verify elg_chk #(.WIDTH(WIDTH)) u_elg_chk (.*);

[bench/testbench.sv]
`timescale 1ns / 1ps
module testbench;
	import elg_pkg::*;

	localparam int W = DEF_WIDTH;
	localparam int LIMIT = 8000000;
	localparam int HOLD_CYCLES = 30000;
	localparam int DRAIN_CYCLES = 10000;

	typedef struct {
		logic         func;
		logic [W-1:0] m;
		logic [W-1:0] k;
		logic [W-1:0] r;
		logic [W-1:0] s;
	} sig_req_t;

	typedef struct {
		logic [W-1:0] y;
		logic [W-1:0] r;
		logic [W-1:0] s;
		logic         ok;
		logic         err;
	} sig_res_t;

	logic         clk;
	logic         arst_n;
	logic         in_valid;
	logic         in_stall;
	logic         func;
	logic [W-1:0] message_hash;
	logic [W-1:0] nonce;
	logic [W-1:0] check_r;
	logic [W-1:0] check_s;
	logic         out_valid;
	logic         out_stall;
	logic [W-1:0] public_key;
	logic [W-1:0] sig_r;
	logic [W-1:0] sig_s;
	logic         valid_res;
	logic         error_code;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [W-1:0] cfg_data;

	// Configuration as the engine should hold it.
	logic [63:0] key_p;
	logic [63:0] key_g;
	logic [63:0] key_x;

	sig_req_t pending_reqs[$];
	sig_res_t expected_sigs[$];

	int  mismatches;
	int  cycles;
	int  n_sign;
	int  n_verify;
	int  n_accepted;
	int  n_nonce_err;
	bit  started;
	bit  no_idle;
	bit  in_taken;
	bit  out_taken;
	bit  hold_go;
	bit  hold_stall;
	int  tx_gap;
	int  rx_gap;

	elgamal_sign_verify u_top (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [63:0] pow_mod(logic [63:0] base, logic [63:0] e, logic [63:0] m);
		logic [63:0] acc;
		acc = 1;
		base = base % m;
		while (e != 0) begin
			if (e[0])
				acc = (acc * base) % m;
			base = (base * base) % m;
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic bit inv_mod(logic [63:0] a, logic [63:0] n, output logic [63:0] res);
		logic [63:0] r0, r1, t0, t1, q, nr, nt;
		res = 0;
		if (n == 1)
			return 1'b1;
		r0 = n;
		r1 = a % n;
		t0 = 0;
		t1 = 1;
		while (r1 != 0) begin
			q = r0 / r1;
			nr = r0 - q * r1;
			nt = (t0 + n - ((q % n) * t1) % n) % n;
			r0 = r1;
			r1 = nr;
			t0 = t1;
			t1 = nt;
		end
		if (r0 != 1)
			return 1'b0;
		res = t0;
		return 1'b1;
	endfunction

	function automatic sig_res_t elg_predict(sig_req_t q);
		sig_res_t    o;
		logic [63:0] n, kinv, rr, xr, d, lhs, rhs;
		o = '{default: '0};
		if (key_p < 2) begin
			o.err = (q.func == FUNC_SIGN) ? ERR_NO_INV : ERR_NONE;
		end else begin
			n = key_p - 1;
			o.y = W'(pow_mod(key_g, key_x, key_p));
			if (q.func == FUNC_SIGN) begin
				if (inv_mod(q.k, n, kinv)) begin
					rr = pow_mod(key_g, q.k, key_p);
					xr = ((key_x % n) * (rr % n)) % n;
					d = ((q.m % n) + n - xr) % n;
					o.r = W'(rr);
					o.s = W'((kinv * d) % n);
				end else begin
					o.err = ERR_NO_INV;
				end
			end else if (q.r != 0 && q.r < key_p && q.s < n) begin
				lhs = pow_mod(key_g, q.m, key_p);
				rhs = (pow_mod({32'd0, o.y}, q.r, key_p) * pow_mod(q.r, q.s, key_p)) % key_p;
				o.ok = (lhs == rhs);
			end
		end
		return o;
	endfunction

	function automatic int draw_wait();
		if (no_idle || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 10);
	endfunction

	function automatic sig_req_t make_req(logic f, logic [W-1:0] m, logic [W-1:0] k,
			logic [W-1:0] r, logic [W-1:0] s);
		sig_req_t q;
		q.func = f;
		q.m = m;
		q.k = k;
		q.r = r;
		q.s = s;
		return q;
	endfunction

	// Builds a verify request carrying a genuine signature of m under the current key.
	function automatic sig_req_t signed_pair(logic [W-1:0] m);
		sig_req_t    q;
		sig_res_t    o;
		logic [63:0] kinv;
		int          tries;
		q = make_req(FUNC_SIGN, m, $urandom | 1, 0, 0);
		tries = 0;
		while (key_p >= 2 && !inv_mod(q.k, key_p - 1, kinv) && tries < 50) begin
			q.k = $urandom | 1;
			tries++;
		end
		o = elg_predict(q);
		return make_req(FUNC_VERIFY, m, $urandom, o.r, o.s);
	endfunction

	function automatic sig_req_t random_req();
		sig_req_t q;
		int       pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			q = make_req(FUNC_SIGN, $urandom, $urandom | 1, $urandom, $urandom);
			if ($urandom_range(0, 4) == 0)
				q.k = $urandom & ~32'd1;
		end else if (pick < 75) begin
			q = signed_pair($urandom);
		end else if (pick < 90) begin
			q = signed_pair($urandom);
			case ($urandom_range(0, 2))
				0: q.r[$urandom_range(0, W - 1)] ^= 1'b1;
				1: q.s[$urandom_range(0, W - 1)] ^= 1'b1;
				default: q.m[$urandom_range(0, W - 1)] ^= 1'b1;
			endcase
		end else begin
			q = make_req(FUNC_VERIFY, $urandom, $urandom, $urandom, $urandom);
		end
		return q;
	endfunction

	task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
		$display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_MODULUS:   key_p = 64'(val);
			REG_GENERATOR: key_g = 64'(val);
			default:       key_x = 64'(val);
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_key(logic [W-1:0] p, logic [W-1:0] g, logic [W-1:0] x);
		write_reg(REG_MODULUS, p);
		write_reg(REG_GENERATOR, g);
		write_reg(REG_PRIVKEY, x);
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() != 0 || in_valid || expected_sigs.size() != 0)
			@(posedge clk);
	endtask

	task automatic push_directed();
		logic [W-1:0] n;
		n = W'(key_p - 1);
		pending_reqs.push_back(make_req(FUNC_SIGN, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(FUNC_SIGN, '1, 1, '1, '1));
		pending_reqs.push_back(make_req(FUNC_SIGN, 3, 3, 0, 0));
		pending_reqs.push_back(make_req(FUNC_SIGN, 1, '1, 0, 0));
		pending_reqs.push_back(signed_pair(0));
		pending_reqs.push_back(signed_pair('1));
		pending_reqs.push_back(make_req(FUNC_VERIFY, 1, 0, 0, 1));
		pending_reqs.push_back(make_req(FUNC_VERIFY, 1, 0, W'(key_p), 1));
		pending_reqs.push_back(make_req(FUNC_VERIFY, 1, 0, 1, n));
		pending_reqs.push_back(make_req(FUNC_VERIFY, '1, '1, '1, '1));
	endtask

	// Sender: offers the next pending request after a random gap.
	always @(negedge clk) begin
		if (started && (!in_valid || in_taken)) begin
			if (tx_gap > 0) begin
				tx_gap--;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				sig_req_t q;
				q = pending_reqs.pop_front();
				func <= q.func;
				message_hash <= q.m;
				nonce <= q.k;
				check_r <= q.r;
				check_s <= q.s;
				in_valid <= 1'b1;
				tx_gap = draw_wait();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus the long hold-off when requested.
	always @(negedge clk) begin
		if (out_taken)
			rx_gap = draw_wait();
		else if (rx_gap > 0)
			rx_gap--;
		out_stall <= hold_stall || rx_gap > 0;
	end

	initial begin
		wait (hold_go);
		@(negedge clk);
		hold_stall <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_stall <= 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
		if (arst_n) begin
			in_taken <= in_valid && !in_stall;
			out_taken <= out_valid && !out_stall;
			if (in_valid && !in_stall) begin
				expected_sigs.push_back(elg_predict(make_req(func, message_hash, nonce,
					check_r, check_s)));
				n_accepted++;
				if (func == FUNC_SIGN)
					n_sign++;
				else
					n_verify++;
			end
			if (out_valid && !out_stall) begin
				if (expected_sigs.size() == 0) begin
					report_mismatch("unexpected result, public_key", public_key, '0);
				end else begin
					sig_res_t e;
					e = expected_sigs.pop_front();
					if (public_key !== e.y)
						report_mismatch("public_key", public_key, e.y);
					if (sig_r !== e.r)
						report_mismatch("sig_r", sig_r, e.r);
					if (sig_s !== e.s)
						report_mismatch("sig_s", sig_s, e.s);
					if (valid_res !== e.ok)
						report_mismatch("valid_res", W'(valid_res), W'(e.ok));
					if (error_code !== e.err)
						report_mismatch("error_code", W'(error_code), W'(e.err));
					if (e.err == ERR_NO_INV)
						n_nonce_err++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_SIGN;
		message_hash = '0;
		nonce = '0;
		check_r = '0;
		check_s = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MODULUS;
		cfg_data = '0;
		key_p = 64'(RST_MODULUS);
		key_g = 64'(RST_GENERATOR);
		key_x = 64'(RST_PRIVKEY);
		mismatches = 0;
		cycles = 0;
		tx_gap = 0;
		rx_gap = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		started = 1'b1;

		// Reset key first, then degenerate and tiny moduli.
		push_directed();
		wait_idle();

		set_key(11, 2, 3);
		no_idle = 1'b1;
		hold_go = 1'b1;
		repeat (6) pending_reqs.push_back(random_req());
		wait_idle();
		no_idle = 1'b0;

		set_key(2, 1, 0);
		push_directed();
		wait_idle();
		set_key(0, 5, 7);
		repeat (3) pending_reqs.push_back(random_req());
		pending_reqs.push_back(make_req(FUNC_SIGN, 9, 3, 0, 0));
		wait_idle();
		set_key(1, '1, '1);
		pending_reqs.push_back(make_req(FUNC_SIGN, 9, 3, 0, 0));
		pending_reqs.push_back(make_req(FUNC_VERIFY, 9, 3, 1, 0));
		wait_idle();

		set_key(32'hFFFF_FFFB, 2, 32'hFFFF_FFFF);
		push_directed();
		repeat (10) pending_reqs.push_back(random_req());
		wait_idle();

		set_key(65521, 17, 12345);
		repeat (15) pending_reqs.push_back(random_req());
		wait_idle();

		set_key('1, '1, 32'h89AB_CDEF);
		repeat (10) pending_reqs.push_back(random_req());
		wait_idle();

		set_key(23, 5, '1);
		repeat (10) pending_reqs.push_back(random_req());
		wait_idle();

		set_key(32'hFFFF_FFFB, 7, $urandom);
		no_idle = 1'b1;
		repeat (10) pending_reqs.push_back(random_req());
		wait_idle();
		no_idle = 1'b0;
		repeat (10) pending_reqs.push_back(random_req());
		wait_idle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d transfers (%0d sign, %0d verify) over ten key settings,",
			n_accepted, n_sign, n_verify);
		$display("%0d results flagged a nonce without inverse; %0d mismatches",
			n_nonce_err, mismatches);
		if (mismatches == 0 && expected_sigs.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
